[src/ckam_pkg.sv]
// ----------------------------------------------------------------------------
// ckam_pkg
// Shared types and constants of the chroma key alpha mask core.
// ----------------------------------------------------------------------------
package ckam_pkg;

	localparam int PIX_W      = 8;
	localparam int HUE_REG_W  = 15;
	localparam int SV_REG_W   = 9;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] REG_KHL = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KHH = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KSL = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KSH = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KVL = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_KVH = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SHL = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SHH = 4'd7;

	localparam logic [HUE_REG_W-1:0] RST_KHL = 15'd5120;
	localparam logic [HUE_REG_W-1:0] RST_KHH = 15'd10240;
	localparam logic [SV_REG_W-1:0]  RST_KSL = 9'd77;
	localparam logic [SV_REG_W-1:0]  RST_KSH = 9'd256;
	localparam logic [SV_REG_W-1:0]  RST_KVL = 9'd77;
	localparam logic [SV_REG_W-1:0]  RST_KVH = 9'd256;
	localparam logic [HUE_REG_W-1:0] RST_SHL = 15'd3840;
	localparam logic [HUE_REG_W-1:0] RST_SHH = 15'd11520;

	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} pixel_t;

	typedef struct packed {
		logic [HUE_REG_W-1:0] khl;
		logic [HUE_REG_W-1:0] khh;
		logic [SV_REG_W-1:0]  ksl;
		logic [SV_REG_W-1:0]  ksh;
		logic [SV_REG_W-1:0]  kvl;
		logic [SV_REG_W-1:0]  kvh;
		logic [HUE_REG_W-1:0] shl;
		logic [HUE_REG_W-1:0] shh;
	} key_cfg_t;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} hue_sector_t;

	typedef enum logic [1:0] {
		ALPHA_KEY,
		ALPHA_RAMP,
		ALPHA_OPAQUE
	} alpha_sel_t;

endpackage

[src/chroma_key_alpha_mask_core.sv]
// ----------------------------------------------------------------------------
// chroma_key_alpha_mask_core
// HSV chroma key: passes each RGB pixel through with a key alpha byte.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ stream, one beat per pixel, and leave on the m_
// stream with red, green, blue unchanged and an alpha byte: 0 inside the
// hard hue/sat/value window, a linear ramp on the distance from the window
// centre inside the soft hue band, 255 elsewhere.
// Key bounds are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while the stream is idle, as the block does not enforce
// it. Indexes outside the register list are ignored. Throughput is one
// pixel per clock while the receiver takes each beat. The latency is set
// by the two bit-per-stage dividers (hue/saturation, then ramp) plus the
// compare and output stages; QW, the quotient width of the hue divider,
// is the max of 8 and clog2(60*2^HUE_FRAC_BITS + 1).
// Reset clears all valid bits and loads the default key bounds.
// When the receiver stalls, the whole pipeline holds in place and s_tready
// drops until the output beat is taken; no beat is lost or repeated.
// ----------------------------------------------------------------------------
module chroma_key_alpha_mask_core import ckam_pkg::*; #(
	parameter int HUE_FRAC_BITS = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,   // red_in, green_in, blue_in
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,   // red_out, green_out, blue_out, alpha_out
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int HUE_W = $clog2(360 << HUE_FRAC_BITS);

	key_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.khl <= RST_KHL;
			cfg_q.khh <= RST_KHH;
			cfg_q.ksl <= RST_KSL;
			cfg_q.ksh <= RST_KSH;
			cfg_q.kvl <= RST_KVL;
			cfg_q.kvh <= RST_KVH;
			cfg_q.shl <= RST_SHL;
			cfg_q.shh <= RST_SHH;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KHL: cfg_q.khl <= cfg_data[HUE_REG_W-1:0];
				REG_KHH: cfg_q.khh <= cfg_data[HUE_REG_W-1:0];
				REG_KSL: cfg_q.ksl <= cfg_data[SV_REG_W-1:0];
				REG_KSH: cfg_q.ksh <= cfg_data[SV_REG_W-1:0];
				REG_KVL: cfg_q.kvl <= cfg_data[SV_REG_W-1:0];
				REG_KVH: cfg_q.kvh <= cfg_data[SV_REG_W-1:0];
				REG_SHL: cfg_q.shl <= cfg_data[HUE_REG_W-1:0];
				REG_SHH: cfg_q.shh <= cfg_data[HUE_REG_W-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic m_valid_q;

	assign en       = !m_valid_q || m_tready;
	assign s_tready = en;

	logic             hsv_vld;
	logic [HUE_W-1:0] hue;
	logic [PIX_W-1:0] sat, val;
	pixel_t           hsv_pix;

	ckam_hsv #(.HUE_FRAC_BITS(HUE_FRAC_BITS), .HUE_W(HUE_W)) u_hsv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.pix_in   (pixel_t'(s_tdata)),
		.out_valid(hsv_vld),
		.hue      (hue),
		.sat      (sat),
		.val      (val),
		.pix_out  (hsv_pix)
	);

	logic             a_vld;
	logic [PIX_W-1:0] alpha;
	pixel_t           a_pix;

	ckam_alpha #(.HUE_W(HUE_W)) u_alpha (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (hsv_vld),
		.hue      (hue),
		.sat      (sat),
		.val      (val),
		.pix_in   (hsv_pix),
		.cfg      (cfg_q),
		.out_valid(a_vld),
		.alpha    (alpha),
		.pix_out  (a_pix)
	);

	logic [31:0] m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (en) begin
			m_valid_q <= a_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_data_q <= {alpha, a_pix};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while output beat stalled");
	a_stall_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("stalled output beat dropped");
	a_cfg_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we |=> $stable(cfg_q))
		else $error("key bounds changed without a write");

endmodule

[src/ckam_pipe_div.sv]
// ----------------------------------------------------------------------------
// ckam_pipe_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module ckam_pipe_div #(
	parameter int NW = 16,
	parameter int DW = 8,
	parameter int QW = 8,
	parameter int PW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [PW-1:0] pay_in,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output logic [PW-1:0] pay_out
);

	localparam int WW = NW + DW + QW;

	logic          vld_s [QW];
	logic [NW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW];
	logic [PW-1:0] pay_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic          vin;
		logic [NW-1:0] rin;
		logic [DW-1:0] din;
		logic [QW-1:0] qin;
		logic [PW-1:0] pin;
		logic [WW-1:0] trial;
		logic          take;

		if (k == 0) begin : g_head
			assign vin = in_valid;
			assign rin = num;
			assign din = den;
			assign qin = '0;
			assign pin = pay_in;
		end else begin : g_body
			assign vin = vld_s[k-1];
			assign rin = rem_s[k-1];
			assign din = den_s[k-1];
			assign qin = quo_s[k-1];
			assign pin = pay_s[k-1];
		end

		assign trial = WW'(din) << (QW - 1 - k);
		assign take  = WW'(rin) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? NW'(WW'(rin) - trial) : rin;
				den_s[k] <= din;
				quo_s[k] <= (qin << 1) | QW'(take);
				pay_s[k] <= pin;
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign quo       = quo_s[QW-1];
	assign pay_out   = pay_s[QW-1];

endmodule

[src/ckam_hsv.sv]
// ----------------------------------------------------------------------------
// ckam_hsv
// RGB to fixed point HSV: extremes, numerators, two dividers, hue wrap.
// ----------------------------------------------------------------------------
module ckam_hsv import ckam_pkg::*; #(
	parameter int HUE_FRAC_BITS = 6,
	parameter int HUE_W         = $clog2(360 << HUE_FRAC_BITS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  pixel_t           pix_in,
	output logic             out_valid,
	output logic [HUE_W-1:0] hue,
	output logic [PIX_W-1:0] sat,
	output logic [PIX_W-1:0] val,
	output pixel_t           pix_out
);

	localparam int SIXTY = 60 << HUE_FRAC_BITS;
	localparam int HNW   = $clog2(SIXTY * 255 + 128);
	localparam int HQW   = $clog2(SIXTY + 1);
	localparam int QW    = (HQW > PIX_W) ? HQW : PIX_W;
	localparam int SNW   = 16;
	localparam int HPW   = $bits(pixel_t) + 3;
	localparam int HSW   = HUE_W + 2;

	// extremes and sector
	logic [PIX_W-1:0] mx, mn;
	hue_sector_t      sec;
	logic signed [PIX_W:0] nsig;

	always_comb begin
		mx = pix_in.red;
		mn = pix_in.red;
		if (pix_in.green > mx) mx = pix_in.green;
		if (pix_in.blue > mx)  mx = pix_in.blue;
		if (pix_in.green < mn) mn = pix_in.green;
		if (pix_in.blue < mn)  mn = pix_in.blue;
		priority if (pix_in.red == mx) begin
			sec  = SEC_RED;
			nsig = $signed({1'b0, pix_in.green}) - $signed({1'b0, pix_in.blue});
		end else if (pix_in.green == mx) begin
			sec  = SEC_GREEN;
			nsig = $signed({1'b0, pix_in.blue}) - $signed({1'b0, pix_in.red});
		end else begin
			sec  = SEC_BLUE;
			nsig = $signed({1'b0, pix_in.red}) - $signed({1'b0, pix_in.green});
		end
	end

	logic             vld_s1;
	pixel_t           pix_s1;
	logic [PIX_W-1:0] mx_s1, d_s1, nabs_s1;
	hue_sector_t      sec_s1;
	logic             neg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1  <= pix_in;
			mx_s1   <= mx;
			d_s1    <= mx - mn;
			sec_s1  <= sec;
			neg_s1  <= nsig[PIX_W];
			nabs_s1 <= nsig[PIX_W] ? PIX_W'(-nsig) : PIX_W'(nsig);
		end
	end

	// numerators and divisors
	logic             vld_s2;
	pixel_t           pix_s2;
	logic [HNW-1:0]   hnum_s2;
	logic [PIX_W-1:0] hden_s2, sden_s2, mx_s2;
	logic [SNW-1:0]   snum_s2;
	hue_sector_t      sec_s2;
	logic             neg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s2  <= pix_s1;
			hnum_s2 <= HNW'(SIXTY) * HNW'(nabs_s1) + HNW'(d_s1 >> 1);
			hden_s2 <= (d_s1 == '0) ? PIX_W'(1) : d_s1;
			snum_s2 <= SNW'(255) * SNW'(d_s1) + SNW'(mx_s1 >> 1);
			sden_s2 <= (mx_s1 == '0) ? PIX_W'(1) : mx_s1;
			mx_s2   <= mx_s1;
			sec_s2  <= sec_s1;
			neg_s2  <= neg_s1;
		end
	end

	logic             hvld, svld;
	logic [QW-1:0]    hquo, squo;
	logic [HPW-1:0]   hpay;
	logic [PIX_W-1:0] spay;

	ckam_pipe_div #(.NW(HNW), .DW(PIX_W), .QW(QW), .PW(HPW)) u_hue_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s2),
		.num      (hnum_s2),
		.den      (hden_s2),
		.pay_in   ({pix_s2, sec_s2, neg_s2}),
		.out_valid(hvld),
		.quo      (hquo),
		.pay_out  (hpay)
	);

	ckam_pipe_div #(.NW(SNW), .DW(PIX_W), .QW(QW), .PW(PIX_W)) u_sat_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s2),
		.num      (snum_s2),
		.den      (sden_s2),
		.pay_in   (mx_s2),
		.out_valid(svld),
		.quo      (squo),
		.pay_out  (spay)
	);

	// hue from sector base and signed offset
	hue_sector_t           hsec;
	logic signed [HSW-1:0] base, mag, hsum;

	always_comb begin
		hsec = hue_sector_t'(hpay[2:1]);
		unique case (hsec)
			SEC_RED:   base = '0;
			SEC_GREEN: base = HSW'(2 * SIXTY);
			SEC_BLUE:  base = HSW'(4 * SIXTY);
			default:   base = '0;
		endcase
		mag  = $signed(HSW'(hquo));
		hsum = hpay[0] ? base - mag : base + mag;
		if (hsum < 0) hsum = hsum + HSW'(6 * SIXTY);
	end

	logic             vld_s3;
	logic [HUE_W-1:0] hue_s3;
	logic [PIX_W-1:0] sat_s3, val_s3;
	pixel_t           pix_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= hvld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_s3 <= hsum[HUE_W-1:0];
			sat_s3 <= squo[PIX_W-1:0];
			val_s3 <= spay;
			pix_s3 <= hpay[HPW-1:3];
		end
	end

	assign out_valid = vld_s3;
	assign hue       = hue_s3;
	assign sat       = sat_s3;
	assign val       = val_s3;
	assign pix_out   = pix_s3;

	a_div_align: assert property (@(posedge clk) disable iff (!arst_n) hvld == svld)
		else $error("hue and saturation dividers out of step");
	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		svld |-> (squo >> PIX_W) == '0)
		else $error("saturation quotient above 255");
	a_hue_mag: assert property (@(posedge clk) disable iff (!arst_n)
		hvld |-> hquo <= QW'(SIXTY))
		else $error("hue offset beyond sixty degrees");

endmodule

[src/ckam_alpha.sv]
// ----------------------------------------------------------------------------
// ckam_alpha
// Key window compare, ramp numerator and divisor, pipelined ramp divide, alpha select.
// ----------------------------------------------------------------------------
module ckam_alpha import ckam_pkg::*; #(
	parameter int HUE_W = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [HUE_W-1:0] hue,
	input  logic [PIX_W-1:0] sat,
	input  logic [PIX_W-1:0] val,
	input  pixel_t           pix_in,
	input  key_cfg_t         cfg,
	output logic             out_valid,
	output logic [PIX_W-1:0] alpha,
	output pixel_t           pix_out
);

	localparam int NUMW = (HUE_W > HUE_REG_W) ? HUE_W : HUE_REG_W;
	localparam int RNW  = NUMW + 8;
	localparam int DENW = HUE_REG_W + 2;
	localparam int APW  = $bits(pixel_t) + 2;

	logic [NUMW-1:0]        hue_e, mid_e, khl_e, khh_e, shl_e, shh_e;
	logic [HUE_REG_W:0]     msum;
	logic                   key, in_band, ge;
	logic signed [DENW-1:0] den;
	logic [NUMW-1:0]        num;
	alpha_sel_t             sel;

	always_comb begin
		msum    = {1'b0, cfg.khl} + {1'b0, cfg.khh};
		hue_e   = NUMW'(hue);
		mid_e   = NUMW'(msum[HUE_REG_W:1]);
		khl_e   = NUMW'(cfg.khl);
		khh_e   = NUMW'(cfg.khh);
		shl_e   = NUMW'(cfg.shl);
		shh_e   = NUMW'(cfg.shh);
		key     = hue_e > khl_e && hue_e < khh_e &&
			{1'b0, sat} > cfg.ksl && {1'b0, sat} < cfg.ksh &&
			{1'b0, val} > cfg.kvl && {1'b0, val} < cfg.kvh;
		in_band = hue_e > shl_e && hue_e < shh_e;
		ge      = hue_e >= mid_e;
		if (ge) begin
			num = hue_e - mid_e;
			den = $signed({2'b0, cfg.shh}) - $signed({2'b0, msum[HUE_REG_W:1]});
		end else begin
			num = mid_e - hue_e;
			den = $signed({2'b0, msum[HUE_REG_W:1]}) - $signed({2'b0, cfg.shl});
		end
		priority if (key) sel = ALPHA_KEY;
		else if (in_band) sel = ALPHA_RAMP;
		else              sel = ALPHA_OPAQUE;
	end

	logic                   vld_s1;
	alpha_sel_t             sel_s1;
	logic [NUMW-1:0]        num_s1;
	logic signed [DENW-1:0] den_s1;
	pixel_t                 pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s1 <= sel;
			num_s1 <= num;
			den_s1 <= den;
			pix_s1 <= pix_in;
		end
	end

	// scaled numerator and saturation check
	logic [RNW-1:0] prod;
	logic           den_bad, big, ramp_ok;

	always_comb begin
		prod    = RNW'(255) * RNW'(num_s1);
		den_bad = den_s1 <= 0;
		big     = prod >= (RNW'(den_s1[HUE_REG_W-1:0]) << 8);
		ramp_ok = sel_s1 == ALPHA_RAMP && !den_bad && !big;
	end

	logic                 vld_s2;
	alpha_sel_t           sel_s2;
	logic [RNW-1:0]       rnum_s2;
	logic [HUE_REG_W-1:0] rden_s2;
	pixel_t               pix_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s2  <= (sel_s1 == ALPHA_RAMP && !ramp_ok) ? ALPHA_OPAQUE : sel_s1;
			rnum_s2 <= ramp_ok ? prod : '0;
			rden_s2 <= ramp_ok ? den_s1[HUE_REG_W-1:0] : HUE_REG_W'(1);
			pix_s2  <= pix_s1;
		end
	end

	logic             dvld;
	logic [PIX_W-1:0] dquo;
	logic [APW-1:0]   dpay;
	alpha_sel_t       dsel;

	ckam_pipe_div #(.NW(RNW), .DW(HUE_REG_W), .QW(PIX_W), .PW(APW)) u_ramp_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s2),
		.num      (rnum_s2),
		.den      (rden_s2),
		.pay_in   ({pix_s2, sel_s2}),
		.out_valid(dvld),
		.quo      (dquo),
		.pay_out  (dpay)
	);

	always_comb begin
		dsel = alpha_sel_t'(dpay[1:0]);
		unique case (dsel)
			ALPHA_KEY:    alpha = '0;
			ALPHA_RAMP:   alpha = dquo;
			ALPHA_OPAQUE: alpha = '1;
			default:      alpha = '1;
		endcase
	end

	assign out_valid = dvld;
	assign pix_out   = dpay[APW-1:2];

endmodule
